// ===== design/assert_macros.svh =====
// Assertion helpers for the camera basis design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== design/cbla_pkg.sv =====
package cbla_pkg;

  // Unit vector format: sign, integer bit, UNIT_FRAC_BITS fraction bits
  localparam int UNIT_FRAC_BITS = 14;
  localparam int UW    = UNIT_FRAC_BITS + 2;   // signed unit component
  localparam int QW    = UNIT_FRAC_BITS + 1;   // unsigned quotient
  localparam int XW    = 2 * UW + 1;           // cross product component
  localparam int DW    = 33;                   // target minus origin
  localparam int IN_W  = (XW > DW) ? XW : DW;  // normalizer input component
  localparam int MW    = 30;                   // scaled magnitude
  localparam int NORM_TOP = MW - 1;            // leading one lands here
  localparam int SW    = 2 * MW + 2;           // sum of squares
  localparam int RW    = MW + 1;               // square root
  localparam int RMW   = RW + 3;               // square root remainder
  localparam int DVW   = RW + QW;              // divider remainder
  localparam int SHW   = $clog2(IN_W);         // shift amount
  localparam int OUT_W = 16;
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  // Focal length
  localparam int WIDTH_W   = 13;
  localparam int FOCAL_W   = 29;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd800;
  localparam logic [40:0] FOCAL_K = 41'd1327227941882;
  localparam int FK_LO_W = 21;
  localparam int FK_HI_W = 20;
  localparam int FP_W    = WIDTH_W + 41;
  localparam int FOCAL_SHIFT = 24;

  typedef logic [2:0][UW-1:0]    uvec_t;
  typedef logic [2:0][IN_W-1:0]  xvec_t;
  typedef logic [2:0][OUT_W-1:0] ovec_t;

  typedef struct packed {
    uvec_t n;
    uvec_t u;
    uvec_t v;
    logic  helper_x;
    logic  degen;
  } side_t;

  typedef struct packed {
    ovec_t normal;
    ovec_t right;
    ovec_t up;
    logic  degen;
  } result_t;

  typedef enum logic [1:0] {
    STEP_DIR,
    STEP_FIRST,
    STEP_SECOND
  } step_t;

  localparam uvec_t X_AXIS = {UW'(0), UW'(0), UW'(1)};
  localparam uvec_t Y_AXIS = {UW'(0), UW'(1), UW'(0)};

  function automatic xvec_t cross3(uvec_t a, uvec_t b);
    logic signed [XW-1:0] w0, w1, w2;
    xvec_t res;
    w0 = XW'($signed(a[1])) * XW'($signed(b[2])) - XW'($signed(a[2])) * XW'($signed(b[1]));
    w1 = XW'($signed(a[2])) * XW'($signed(b[0])) - XW'($signed(a[0])) * XW'($signed(b[2]));
    w2 = XW'($signed(a[0])) * XW'($signed(b[1])) - XW'($signed(a[1])) * XW'($signed(b[0]));
    res[0] = IN_W'(w0);
    res[1] = IN_W'(w1);
    res[2] = IN_W'(w2);
    return res;
  endfunction

  function automatic logic [UW:0] umag(logic [UW-1:0] v);
    logic [UW:0] ext;
    ext = {v[UW-1], v};
    return ext[UW] ? -ext : ext;
  endfunction

  function automatic logic [OUT_W-1:0] pack16(logic [UW-1:0] v);
    logic signed [UW-1:0] s;
    logic [OUT_W-1:0] res;
    s = $signed(v);
    res = OUT_W'(s);
    if (s > OUT_MAX) res = OUT_W'(OUT_MAX);
    if (s < OUT_MIN) res = OUT_W'(OUT_MIN);
    return res;
  endfunction

  function automatic ovec_t pack_vec(uvec_t v);
    ovec_t res;
    for (int c = 0; c < 3; c++) res[c] = pack16(v[c]);
    return res;
  endfunction

endpackage

// ===== design/cbla_in_if.sv =====
interface cbla_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, target_x, target_y, target_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, target_x, target_y, target_z,
    output ready
  );
endinterface

// ===== design/cbla_out_if.sv =====
interface cbla_out_if;
  import cbla_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic [FOCAL_W-1:0] focal_length;
  logic               degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, right_x, right_y, right_z,
           up_x, up_y, up_z, focal_length, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, right_x, right_y, right_z,
           up_x, up_y, up_z, focal_length, degenerate,
    output ready
  );
endinterface

// ===== design/cbla_unitize.sv =====
module cbla_unitize (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  cbla_pkg::xvec_t  in_vec,
  input  cbla_pkg::side_t  in_side,
  output logic             out_valid,
  output cbla_pkg::uvec_t  out_vec,
  output cbla_pkg::side_t  out_side
);
  import cbla_pkg::*;

  typedef logic [2:0][MW-1:0]    mvec_t;
  typedef logic [2:0][2*MW-1:0]  sqvec_t;
  typedef logic [2:0][DVW-1:0]   rvec_t;
  typedef logic [2:0][QW-1:0]    qvec_t;

  typedef struct packed {
    mvec_t      m;
    logic [2:0] neg;
    logic       zero;
    side_t      side;
  } carry_t;

  function automatic logic [SHW-1:0] lead_pos(logic [IN_W-1:0] x);
    logic [SHW-1:0] p;
    p = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (x[i]) p = SHW'(i);
    end
    return p;
  endfunction

  // Stage A: magnitudes and largest magnitude
  xvec_t           a_mag_next;
  logic [IN_W-1:0] a_mx_next;
  logic            a_valid;
  xvec_t           a_mag;
  logic [2:0]      a_neg;
  logic [IN_W-1:0] a_mx;
  side_t           a_side;

  always_comb begin
    a_mx_next = '0;
    for (int c = 0; c < 3; c++) begin
      a_mag_next[c] = in_vec[c][IN_W-1] ? IN_W'(-in_vec[c]) : in_vec[c];
      if (a_mag_next[c] > a_mx_next) a_mx_next = a_mag_next[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= in_valid;
    if (en) begin
      a_mag <= a_mag_next;
      a_mx  <= a_mx_next;
      for (int c = 0; c < 3; c++) a_neg[c] <= in_vec[c][IN_W-1];
      a_side <= in_side;
    end
  end

  // Stage B: locate the leading one of the largest magnitude
  logic           b_valid;
  xvec_t          b_mag;
  logic [2:0]     b_neg;
  logic [SHW-1:0] b_pos;
  logic           b_zero;
  side_t          b_side;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
    if (en) begin
      b_mag  <= a_mag;
      b_neg  <= a_neg;
      b_pos  <= lead_pos(a_mx);
      b_zero <= (a_mx == '0);
      b_side <= a_side;
    end
  end

  // Stage C: scale so the largest magnitude sits just below 2^30
  mvec_t  c_m_next;
  logic   c_valid;
  carry_t c_carry;

  always_comb begin
    logic [IN_W-1:0] tmp;
    tmp = '0;
    for (int c = 0; c < 3; c++) begin
      if (b_pos >= SHW'(NORM_TOP)) tmp = b_mag[c] >> (b_pos - SHW'(NORM_TOP));
      else tmp = b_mag[c] << (SHW'(NORM_TOP) - b_pos);
      c_m_next[c] = tmp[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (en) c_valid <= b_valid;
    if (en) begin
      c_carry.m    <= c_m_next;
      c_carry.neg  <= b_neg;
      c_carry.zero <= b_zero;
      c_carry.side <= b_side;
    end
  end

  // Stage D: squares
  logic   d_valid;
  sqvec_t d_sq;
  carry_t d_carry;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (en) d_valid <= c_valid;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        d_sq[c] <= (2*MW)'(c_carry.m[c]) * (2*MW)'(c_carry.m[c]);
      end
      d_carry <= c_carry;
    end
  end

  // Stage E and square root: one result bit per stage
  logic           sq_v    [RW+1];
  logic [SW-1:0]  sq_s    [RW+1];
  logic [RMW-1:0] sq_rem  [RW+1];
  logic [RW-1:0]  sq_root [RW+1];
  carry_t         sq_c    [RW+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= d_valid;
    if (en) begin
      sq_s[0]    <= SW'(d_sq[0]) + SW'(d_sq[1]) + SW'(d_sq[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_c[0]    <= d_carry;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;

    assign rem_sh = {sq_rem[k][RMW-3:0], sq_s[k][SW-1:SW-2]};
    assign trial  = RMW'({sq_root[k], 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (en) sq_v[k+1] <= sq_v[k];
      if (en) begin
        sq_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
        sq_s[k+1]    <= sq_s[k] << 2;
        sq_c[k+1]    <= sq_c[k];
      end
    end
  end

  // Divider setup: rounded numerators
  logic          dv_v   [QW+1];
  logic [RW-1:0] dv_r   [QW+1];
  rvec_t         dv_rem [QW+1];
  qvec_t         dv_q   [QW+1];
  carry_t        dv_c   [QW+1];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= sq_v[RW];
    if (en) begin
      dv_r[0] <= sq_root[RW];
      for (int c = 0; c < 3; c++) begin
        dv_rem[0][c] <= (DVW'(sq_c[RW].m[c]) << UNIT_FRAC_BITS) + DVW'(sq_root[RW] >> 1);
      end
      dv_q[0] <= '0;
      dv_c[0] <= sq_c[RW];
    end
  end

  // Restoring divide: one quotient bit per stage, three lanes
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DVW-1:0] dvs;
    rvec_t          rem_next;
    qvec_t          q_next;

    assign dvs = DVW'(dv_r[k]) << (QW - 1 - k);

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if (dv_rem[k][c] >= dvs) begin
          rem_next[c] = dv_rem[k][c] - dvs;
          q_next[c]   = {dv_q[k][c][QW-2:0], 1'b1};
        end else begin
          rem_next[c] = dv_rem[k][c];
          q_next[c]   = {dv_q[k][c][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (en) dv_v[k+1] <= dv_v[k];
      if (en) begin
        dv_r[k+1]   <= dv_r[k];
        dv_rem[k+1] <= rem_next;
        dv_q[k+1]   <= q_next;
        dv_c[k+1]   <= dv_c[k];
      end
    end
  end

  // Apply signs, force zero vectors to zero
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_v[QW];
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        if (dv_c[QW].zero) out_vec[c] <= '0;
        else if (dv_c[QW].neg[c]) out_vec[c] <= UW'(-{1'b0, dv_q[QW][c]});
        else out_vec[c] <= UW'({1'b0, dv_q[QW][c]});
      end
      out_side <= dv_c[QW].side;
    end
  end

endmodule

// ===== design/cbla_cross.sv =====
module cbla_cross (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  cbla_pkg::step_t  step,
  input  logic             in_valid,
  input  cbla_pkg::uvec_t  in_vec,
  input  cbla_pkg::side_t  in_side,
  output logic             out_valid,
  output cbla_pkg::xvec_t  out_vec,
  output cbla_pkg::side_t  out_side
);
  import cbla_pkg::*;

  side_t side_next;
  xvec_t vec_next;

  // Store the fresh unit vector and form the next cross product
  always_comb begin
    side_next = in_side;
    vec_next  = '0;
    case (step)
      STEP_DIR: begin
        side_next.n        = in_vec;
        side_next.helper_x = (umag(in_vec[1]) > umag(in_vec[2]));
        if (side_next.helper_x) vec_next = cross3(X_AXIS, in_vec);
        else vec_next = cross3(in_vec, Y_AXIS);
      end
      STEP_FIRST: begin
        if (in_side.helper_x) begin
          side_next.v = in_vec;
          vec_next    = cross3(in_side.n, in_vec);
        end else begin
          side_next.u = in_vec;
          vec_next    = cross3(in_vec, in_side.n);
        end
      end
      STEP_SECOND: begin
        if (in_side.helper_x) side_next.u = in_vec;
        else side_next.v = in_vec;
        vec_next = cross3(side_next.v, side_next.u);
      end
      default: begin
        vec_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
    if (en) begin
      out_vec  <= vec_next;
      out_side <= side_next;
    end
  end

endmodule

// ===== design/camera_basis_look_at_unit.sv =====
// Look-at camera basis.
// camera (valid/ready sink): origin and target, signed Q16.16 each.
// basis (valid/ready source): view normal, right and up unit vectors in
//   signed Q1.14, focal length in unsigned Q13.16 and a degenerate flag
//   that is set, with all vectors zero, when origin equals target.
// cfg_we/cfg_wdata: viewport width in pixels, 800 after reset; write it
//   only while no camera is in flight.
// One camera enters per cycle while camera.ready is high. An accepted beat
//   passes one difference stage (loaded at the accepting edge), four
//   normalizers of 53 stages each (31 square root stages, 15 divide
//   stages and 7 others), three cross product stages and the output
//   queue before it goes valid on basis.
// Reset clears every valid bit and the output queue and restores the width.
// The pipeline feeds a two-entry output queue and advances while the
//   queue has room, so a camera is still taken while one result waits;
//   with both entries held the pipeline freezes in place and camera.ready
//   drops until basis takes a beat.
`include "assert_macros.svh"
module camera_basis_look_at_unit (
  input  logic                          clk,
  input  logic                          rst,
  cbla_in_if.sink                       camera,
  cbla_out_if.source                    basis,
  input  logic                          cfg_we,
  input  logic [cbla_pkg::WIDTH_W-1:0]  cfg_wdata
);
  import cbla_pkg::*;

  // Viewport width register
  logic [WIDTH_W-1:0] image_width;

  always_ff @(posedge clk) begin
    if (rst) image_width <= WIDTH_RESET;
    else if (cfg_we) image_width <= cfg_wdata;
  end

  // Focal length: split multiply, then round and saturate
  logic [WIDTH_W+FK_HI_W-1:0] f_hi;
  logic [WIDTH_W+FK_LO_W-1:0] f_lo;
  logic [FP_W-1:0]            f_sum;
  logic [FOCAL_W-1:0]         focal;

  assign f_sum = (FP_W'(f_hi) << FK_LO_W) + FP_W'(f_lo) + (FP_W'(1) << (FOCAL_SHIFT - 1));

  always_ff @(posedge clk) begin
    f_hi <= (WIDTH_W+FK_HI_W)'(image_width) * (WIDTH_W+FK_HI_W)'(FOCAL_K[40:FK_LO_W]);
    f_lo <= (WIDTH_W+FK_LO_W)'(image_width) * (WIDTH_W+FK_LO_W)'(FOCAL_K[FK_LO_W-1:0]);
    if (f_sum[FP_W-1:FOCAL_SHIFT+FOCAL_W] != '0) focal <= '1;
    else focal <= f_sum[FOCAL_SHIFT+FOCAL_W-1:FOCAL_SHIFT];
  end

  // Output queue state and pipeline advance
  result_t    q0, q1;
  logic [1:0] cnt;
  logic       en;
  logic       push, pop;

  assign en = (cnt != 2'd2);
  assign camera.ready = en && !rst;

  // Difference stage
  logic  d_valid;
  xvec_t d_vec;
  side_t d_side;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (en) d_valid <= camera.valid;
    if (en) begin
      d_vec[0] <= IN_W'(camera.target_x) - IN_W'(camera.origin_x);
      d_vec[1] <= IN_W'(camera.target_y) - IN_W'(camera.origin_y);
      d_vec[2] <= IN_W'(camera.target_z) - IN_W'(camera.origin_z);
      d_side.n <= '0;
      d_side.u <= '0;
      d_side.v <= '0;
      d_side.helper_x <= 1'b0;
      d_side.degen <= (camera.target_x == camera.origin_x) &&
                      (camera.target_y == camera.origin_y) &&
                      (camera.target_z == camera.origin_z);
    end
  end

  // Normalize, cross, normalize, cross, normalize, cross, normalize
  logic  n1_valid, x1_valid, n2_valid, x2_valid, n3_valid, x3_valid, n4_valid;
  uvec_t n1_vec, n2_vec, n3_vec, n4_vec;
  xvec_t x1_vec, x2_vec, x3_vec;
  side_t n1_side, x1_side, n2_side, x2_side, n3_side, x3_side, n4_side;

  cbla_unitize u_unit_dir (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d_valid), .in_vec(d_vec), .in_side(d_side),
    .out_valid(n1_valid), .out_vec(n1_vec), .out_side(n1_side)
  );

  cbla_cross u_cross_dir (
    .clk(clk), .rst(rst), .en(en), .step(STEP_DIR),
    .in_valid(n1_valid), .in_vec(n1_vec), .in_side(n1_side),
    .out_valid(x1_valid), .out_vec(x1_vec), .out_side(x1_side)
  );

  cbla_unitize u_unit_first (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(x1_valid), .in_vec(x1_vec), .in_side(x1_side),
    .out_valid(n2_valid), .out_vec(n2_vec), .out_side(n2_side)
  );

  cbla_cross u_cross_first (
    .clk(clk), .rst(rst), .en(en), .step(STEP_FIRST),
    .in_valid(n2_valid), .in_vec(n2_vec), .in_side(n2_side),
    .out_valid(x2_valid), .out_vec(x2_vec), .out_side(x2_side)
  );

  cbla_unitize u_unit_second (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(x2_valid), .in_vec(x2_vec), .in_side(x2_side),
    .out_valid(n3_valid), .out_vec(n3_vec), .out_side(n3_side)
  );

  cbla_cross u_cross_second (
    .clk(clk), .rst(rst), .en(en), .step(STEP_SECOND),
    .in_valid(n3_valid), .in_vec(n3_vec), .in_side(n3_side),
    .out_valid(x3_valid), .out_vec(x3_vec), .out_side(x3_side)
  );

  cbla_unitize u_unit_normal (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(x3_valid), .in_vec(x3_vec), .in_side(x3_side),
    .out_valid(n4_valid), .out_vec(n4_vec), .out_side(n4_side)
  );

  // Assemble the result beat
  result_t fin;

  always_comb begin
    fin.normal = pack_vec(n4_vec);
    fin.right  = pack_vec(n4_side.u);
    fin.up     = pack_vec(n4_side.v);
    fin.degen  = n4_side.degen;
  end

  // Two-entry output queue
  assign push = en && n4_valid;
  assign pop  = basis.valid && basis.ready;

  always_ff @(posedge clk) begin
    if (rst) cnt <= 2'd0;
    else cnt <= cnt + 2'(push) - 2'(pop);
    if (pop) begin
      if (cnt == 2'd2) q0 <= q1;
      else if (push) q0 <= fin;
    end else if (push) begin
      if (cnt == 2'd0) q0 <= fin;
      else q1 <= fin;
    end
  end

  assign basis.valid        = (cnt != 2'd0);
  assign basis.normal_x     = q0.normal[0];
  assign basis.normal_y     = q0.normal[1];
  assign basis.normal_z     = q0.normal[2];
  assign basis.right_x      = q0.right[0];
  assign basis.right_y      = q0.right[1];
  assign basis.right_z      = q0.right[2];
  assign basis.up_x         = q0.up[0];
  assign basis.up_y         = q0.up[1];
  assign basis.up_z         = q0.up[2];
  assign basis.focal_length = focal;
  assign basis.degenerate   = q0.degen;

  `ASSERT_CLK(a_degen_zero, (basis.valid && basis.degenerate) |-> (basis.normal_x == 16'sd0 && basis.right_y == 16'sd0 && basis.up_z == 16'sd0), "degenerate beat carries a nonzero vector")
  `ASSERT_CLK(a_unit_range, basis.valid |-> ($signed(basis.normal_x) <= 16384 && $signed(basis.normal_x) >= -16384), "normal component out of unit range")
  `ASSERT_ALWAYS(a_accept_enters, (camera.valid && camera.ready && !rst) |=> d_valid, "accepted camera beat lost at entry")

endmodule
